>>> sv/ptp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task picker package
// Shared defaults, operation and wait codes, and the slot memory word layout.
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam int SLOTS_DEF    = 8;
    localparam int LOCKS_DEF    = 32;
    localparam int CHANNELS_DEF = 16;

    localparam int TIME_W = 64;
    localparam int ID_W   = 5;
    localparam int PRIO_W = 8;
    localparam int CHAN_W = 16;

    localparam logic [2:0] OP_SELECT   = 3'd0;
    localparam logic [2:0] OP_LOAD     = 3'd1;
    localparam logic [2:0] OP_SET_WAIT = 3'd2;
    localparam logic [2:0] OP_RELEASE  = 3'd3;
    localparam logic [2:0] OP_DMA_DONE = 3'd4;
    localparam logic [2:0] OP_ALARM    = 3'd5;

    localparam logic [1:0] WAIT_READY = 2'd0;
    localparam logic [1:0] WAIT_ALARM = 2'd1;
    localparam logic [1:0] WAIT_LOCK  = 2'd2;
    localparam logic [1:0] WAIT_DMA   = 2'd3;

    typedef struct packed {
        logic                     present;
        logic signed [PRIO_W-1:0] prio;
        logic [1:0]               wait_kind;
        logic [ID_W-1:0]          awaited;
        logic [TIME_W-1:0]        last_run;
    } slot_word_t;

    typedef struct packed {
        logic woke;
        logic eligible;
    } wake_status_t;

endpackage

>>> sv/ptp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module ptp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/ptp_wake.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot wake evaluation
// Decides whether a waiting slot wakes and whether it can compete in a select.
// ----------------------------------------------------------------------------
module ptp_wake (
    input  ptp_pkg::slot_word_t                cur,
    input  logic                               lock_in,
    input  logic [ptp_pkg::TIME_W-1:0]         lock_time,
    input  logic                               dma_in,
    input  logic [ptp_pkg::TIME_W-1:0]         dma_time,
    input  logic                               chan_busy,
    output ptp_pkg::slot_word_t                nxt,
    output ptp_pkg::wake_status_t              status
);

    logic lock_hit;
    logic dma_hit;
    logic woke;

    assign lock_hit = lock_in && (lock_time >= cur.last_run);
    assign dma_hit  = !dma_in || !chan_busy || (dma_time >= cur.last_run);
    assign woke     = cur.present
                      && (((cur.wait_kind == ptp_pkg::WAIT_LOCK) && lock_hit)
                      || ((cur.wait_kind == ptp_pkg::WAIT_DMA) && dma_hit));

    always_comb
    begin
        nxt = cur;
        if (woke)
        begin
            nxt.wait_kind = ptp_pkg::WAIT_READY;
            nxt.awaited   = '0;
        end
    end

    assign status.woke     = woke;
    assign status.eligible = nxt.present && (nxt.wait_kind == ptp_pkg::WAIT_READY);

endmodule

>>> sv/priority_task_picker_with_wakeups.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task picker with wakeups
// Slot table with lock and DMA wakeups and a rotating-start priority select.
// ----------------------------------------------------------------------------
// Select: the walk reads one slot per cycle through the read and wake stages,
// then the result beat is registered in the finish state; no input beat is taken
// until the select is done. Set wait and alarm fire read the slot, then write it back.
// Other items are accepted while a result beat waits on the output register.
// Reset clears control state, slot and lock valid bits and the DMA times;
// unwritten entries read as zero, so no clearing pass is needed.
module priority_task_picker_with_wakeups #(
    parameter int SLOTS    = ptp_pkg::SLOTS_DEF,
    parameter int LOCKS    = ptp_pkg::LOCKS_DEF,
    parameter int CHANNELS = ptp_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          operation,
    input  logic [2:0]                          task_slot,
    input  logic signed [ptp_pkg::PRIO_W-1:0]   priority_req,
    input  logic                                present,
    input  logic [1:0]                          wait_kind,
    input  logic [ptp_pkg::ID_W-1:0]            awaitable,
    input  logic [ptp_pkg::TIME_W-1:0]          now_us,
    input  logic [ptp_pkg::CHAN_W-1:0]          busy_channels,
    input  logic [ptp_pkg::CHAN_W-1:0]          done_channels,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [2:0]                          chosen_slot
);

    localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LAW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
    localparam int CAW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WORD_W = $bits(ptp_pkg::slot_word_t);
    localparam logic [SAW:0]   SlotCount = (SAW + 1)'(SLOTS);
    localparam logic [SAW-1:0] SlotLast  = SAW'(SLOTS - 1);
    localparam logic [6:0]     SlotLimit = 7'(SLOTS);
    localparam logic [5:0]     LockLimit = 6'(LOCKS);
    localparam logic [5:0]     ChanLimit = 6'(CHANNELS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_WALK,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]                     op_reg, op_next;
    logic [SAW-1:0]                 slot_reg, slot_next;
    logic [1:0]                     kind_reg, kind_next;
    logic [ptp_pkg::ID_W-1:0]       aw_reg, aw_next;
    logic [ptp_pkg::TIME_W-1:0]     now_reg, now_next;
    logic [ptp_pkg::CHAN_W-1:0]     busy_reg, busy_next;
    logic                           sval_reg, sval_next;
    logic [SAW-1:0]                 start_offset_reg, start_offset_next;
    logic [SAW-1:0]                 walk_addr_reg, walk_addr_next;
    logic [SAW:0]                   cnt_reg, cnt_next;
    logic                           p1_valid_reg, p1_valid_next;
    logic [SAW-1:0]                 p1_addr_reg, p1_addr_next;
    logic                           p2_valid_reg, p2_valid_next;
    logic [SAW-1:0]                 p2_addr_reg, p2_addr_next;
    ptp_pkg::slot_word_t            p2_word_reg, p2_word_next;
    logic                           p2_lock_in_reg, p2_lock_in_next;
    logic                           p2_lock_v_reg, p2_lock_v_next;
    logic                           p2_dma_in_reg, p2_dma_in_next;
    logic [ptp_pkg::TIME_W-1:0]     p2_dtime_reg, p2_dtime_next;
    logic                           p2_busy_reg, p2_busy_next;
    logic                           have_reg, have_next;
    logic [SAW-1:0]                 best_addr_reg, best_addr_next;
    ptp_pkg::slot_word_t            best_word_reg, best_word_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           found_reg, found_next;
    logic [2:0]                     chosen_reg, chosen_next;
    logic [SLOTS-1:0]               slot_valid_reg, slot_valid_next;
    logic [LOCKS-1:0]               lock_valid_reg, lock_valid_next;
    logic [ptp_pkg::TIME_W-1:0]     dma_time_reg [CHANNELS];
    logic [ptp_pkg::TIME_W-1:0]     dma_time_next [CHANNELS];

    logic                           accept;
    logic                           slot_in_range;
    logic [SAW-1:0]                 slot_idx;

    logic                           s_we;
    logic [SAW-1:0]                 s_waddr;
    ptp_pkg::slot_word_t            s_wdata;
    logic [SAW-1:0]                 s_raddr;
    logic [WORD_W-1:0]              s_rdata;
    ptp_pkg::slot_word_t            rd_word;

    logic                           l_we;
    logic [LAW-1:0]                 l_raddr;
    logic [ptp_pkg::TIME_W-1:0]     l_rdata;

    ptp_pkg::slot_word_t            merged;
    ptp_pkg::slot_word_t            wake_word;
    ptp_pkg::wake_status_t          wake_status;
    logic [ptp_pkg::ID_W-1:0]       rd_id;
    logic                           rd_lock_in;
    logic                           rd_dma_in;

    assign in_stall      = (state_reg != ST_IDLE);
    assign accept        = in_valid && !in_stall;
    assign slot_in_range = ({4'd0, task_slot} < SlotLimit);
    assign slot_idx      = SAW'(task_slot);
    assign rd_word       = sval_reg ? ptp_pkg::slot_word_t'(s_rdata) : '0;
    assign rd_id         = rd_word.awaited;
    assign rd_lock_in    = ({1'b0, rd_id} < LockLimit);
    assign rd_dma_in     = ({1'b0, rd_id} < ChanLimit);
    assign l_raddr       = rd_id[LAW-1:0];

    ptp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    ptp_ram #(
        .WIDTH (ptp_pkg::TIME_W),
        .DEPTH (LOCKS)
    ) u_lock_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (awaitable[LAW-1:0]),
        .wdata (now_us),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    ptp_wake u_wake (
        .cur       (p2_word_reg),
        .lock_in   (p2_lock_in_reg),
        .lock_time (p2_lock_v_reg ? l_rdata : '0),
        .dma_in    (p2_dma_in_reg),
        .dma_time  (p2_dtime_reg),
        .chan_busy (p2_busy_reg),
        .nxt       (wake_word),
        .status    (wake_status)
    );

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        slot_next         = slot_reg;
        kind_next         = kind_reg;
        aw_next           = aw_reg;
        now_next          = now_reg;
        busy_next         = busy_reg;
        sval_next         = sval_reg;
        start_offset_next = start_offset_reg;
        walk_addr_next    = walk_addr_reg;
        cnt_next          = cnt_reg;
        p1_valid_next     = 1'b0;
        p1_addr_next      = p1_addr_reg;
        p2_valid_next     = 1'b0;
        p2_addr_next      = p2_addr_reg;
        p2_word_next      = p2_word_reg;
        p2_lock_in_next   = p2_lock_in_reg;
        p2_lock_v_next    = p2_lock_v_reg;
        p2_dma_in_next    = p2_dma_in_reg;
        p2_dtime_next     = p2_dtime_reg;
        p2_busy_next      = p2_busy_reg;
        have_next         = have_reg;
        best_addr_next    = best_addr_reg;
        best_word_next    = best_word_reg;
        out_valid_next    = out_valid_reg && out_stall;
        found_next        = found_reg;
        chosen_next       = chosen_reg;
        slot_valid_next   = slot_valid_reg;
        lock_valid_next   = lock_valid_reg;
        dma_time_next     = dma_time_reg;
        s_we              = 1'b0;
        s_waddr           = slot_idx;
        s_wdata           = '0;
        s_raddr           = walk_addr_reg;
        l_we              = 1'b0;
        merged            = rd_word;

        case (state_reg)
            ST_IDLE:
            begin
                s_raddr = slot_idx;
                if (accept)
                begin
                    op_next   = operation;
                    slot_next = slot_idx;
                    kind_next = wait_kind;
                    aw_next   = awaitable;
                    now_next  = now_us;
                    busy_next = busy_channels;
                    sval_next = slot_in_range && slot_valid_reg[slot_idx];
                    case (operation)
                        ptp_pkg::OP_SELECT:
                        begin
                            walk_addr_next = start_offset_reg;
                            cnt_next       = '0;
                            have_next      = 1'b0;
                            state_next     = ST_WALK;
                        end
                        ptp_pkg::OP_LOAD:
                        begin
                            if (slot_in_range)
                            begin
                                s_we                      = 1'b1;
                                s_wdata.present           = present;
                                s_wdata.prio              = priority_req;
                                s_wdata.wait_kind         = ptp_pkg::WAIT_READY;
                                slot_valid_next[slot_idx] = 1'b1;
                            end
                        end
                        ptp_pkg::OP_SET_WAIT,
                        ptp_pkg::OP_ALARM:
                        begin
                            if (slot_in_range)
                            begin
                                state_next = ST_RMW;
                            end
                        end
                        ptp_pkg::OP_RELEASE:
                        begin
                            if ({1'b0, awaitable} < LockLimit)
                            begin
                                l_we = 1'b1;
                                lock_valid_next[awaitable[LAW-1:0]] = 1'b1;
                            end
                        end
                        ptp_pkg::OP_DMA_DONE:
                        begin
                            for (int c = 0; c < CHANNELS; c++)
                            begin
                                if (done_channels[c])
                                begin
                                    dma_time_next[c] = now_us;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                if (op_reg == ptp_pkg::OP_SET_WAIT)
                begin
                    merged.wait_kind = kind_reg;
                    merged.awaited   = aw_reg;
                end
                else if (rd_word.wait_kind == ptp_pkg::WAIT_ALARM)
                begin
                    merged.wait_kind = ptp_pkg::WAIT_READY;
                end
                s_we                      = 1'b1;
                s_waddr                   = slot_reg;
                s_wdata                   = merged;
                slot_valid_next[slot_reg] = 1'b1;
                state_next                = ST_IDLE;
            end
            ST_WALK:
            begin
                if (cnt_reg != SlotCount)
                begin
                    p1_valid_next  = 1'b1;
                    p1_addr_next   = walk_addr_reg;
                    sval_next      = slot_valid_reg[walk_addr_reg];
                    walk_addr_next = (walk_addr_reg == SlotLast) ? '0 : walk_addr_reg + 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
                if (p1_valid_reg)
                begin
                    p2_valid_next   = 1'b1;
                    p2_addr_next    = p1_addr_reg;
                    p2_word_next    = rd_word;
                    p2_lock_in_next = rd_lock_in;
                    p2_lock_v_next  = rd_lock_in && lock_valid_reg[rd_id[LAW-1:0]];
                    p2_dma_in_next  = rd_dma_in;
                    p2_dtime_next   = rd_dma_in ? dma_time_reg[rd_id[CAW-1:0]] : '0;
                    p2_busy_next    = rd_dma_in && busy_reg[rd_id[3:0]];
                end
                if (p2_valid_reg)
                begin
                    if (wake_status.woke)
                    begin
                        s_we                         = 1'b1;
                        s_waddr                      = p2_addr_reg;
                        s_wdata                      = wake_word;
                        slot_valid_next[p2_addr_reg] = 1'b1;
                    end
                    if (wake_status.eligible
                        && (!have_reg || (wake_word.prio > best_word_reg.prio)))
                    begin
                        have_next      = 1'b1;
                        best_addr_next = p2_addr_reg;
                        best_word_next = wake_word;
                    end
                end
                if ((cnt_reg == SlotCount) && !p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = have_reg;
                    chosen_next    = have_reg ? 3'(best_addr_reg) : 3'd0;
                    if (have_reg)
                    begin
                        s_we             = 1'b1;
                        s_waddr          = best_addr_reg;
                        s_wdata          = best_word_reg;
                        s_wdata.last_run = now_reg;
                    end
                    start_offset_next = (start_offset_reg == SlotLast) ? '0
                                        : start_offset_reg + 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= '0;
            slot_reg         <= '0;
            kind_reg         <= '0;
            aw_reg           <= '0;
            now_reg          <= '0;
            busy_reg         <= '0;
            sval_reg         <= 1'b0;
            start_offset_reg <= '0;
            walk_addr_reg    <= '0;
            cnt_reg          <= '0;
            p1_valid_reg     <= 1'b0;
            p1_addr_reg      <= '0;
            p2_valid_reg     <= 1'b0;
            p2_addr_reg      <= '0;
            p2_word_reg      <= '0;
            p2_lock_in_reg   <= 1'b0;
            p2_lock_v_reg    <= 1'b0;
            p2_dma_in_reg    <= 1'b0;
            p2_dtime_reg     <= '0;
            p2_busy_reg      <= 1'b0;
            have_reg         <= 1'b0;
            best_addr_reg    <= '0;
            best_word_reg    <= '0;
            out_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            chosen_reg       <= '0;
            slot_valid_reg   <= '0;
            lock_valid_reg   <= '0;
            dma_time_reg     <= '{default: '0};
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            slot_reg         <= slot_next;
            kind_reg         <= kind_next;
            aw_reg           <= aw_next;
            now_reg          <= now_next;
            busy_reg         <= busy_next;
            sval_reg         <= sval_next;
            start_offset_reg <= start_offset_next;
            walk_addr_reg    <= walk_addr_next;
            cnt_reg          <= cnt_next;
            p1_valid_reg     <= p1_valid_next;
            p1_addr_reg      <= p1_addr_next;
            p2_valid_reg     <= p2_valid_next;
            p2_addr_reg      <= p2_addr_next;
            p2_word_reg      <= p2_word_next;
            p2_lock_in_reg   <= p2_lock_in_next;
            p2_lock_v_reg    <= p2_lock_v_next;
            p2_dma_in_reg    <= p2_dma_in_next;
            p2_dtime_reg     <= p2_dtime_next;
            p2_busy_reg      <= p2_busy_next;
            have_reg         <= have_next;
            best_addr_reg    <= best_addr_next;
            best_word_reg    <= best_word_next;
            out_valid_reg    <= out_valid_next;
            found_reg        <= found_next;
            chosen_reg       <= chosen_next;
            slot_valid_reg   <= slot_valid_next;
            lock_valid_reg   <= lock_valid_next;
            dma_time_reg     <= dma_time_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign chosen_slot = chosen_reg;

`ifndef SYNTHESIS
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result beat raised outside the select finish");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (chosen_reg == 3'd0))
        else $error("empty select reports a nonzero slot");

    a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (!p1_valid_reg && !p2_valid_reg && (cnt_reg == SlotCount)))
        else $error("select finished with slots still in the walk pipeline");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= SlotCount))
        else $error("walk visited more slots than the table holds");

    a_pipe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg || p2_valid_reg) |-> (state_reg == ST_WALK))
        else $error("walk pipeline active outside a select");
`endif

endmodule
